@@ rtl/assert_macros.svh @@
// assert_macros.svh: assertion shorthands used by the checker file sfr_checker.
// No dependencies; include with the bare file name. Clock aclk, reset aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is low.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the active-low reset is low.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// sfr_pkg: types and constants for the stream find/replace block.
// No dependencies; imported by stream_find_replace.
package sfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned REPL_MAX  = 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SEARCH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPL_LEN = 3'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPL,
        ST_FLUSH
    } sfr_state_t;

    function automatic logic [BYTE_W-1:0] pick_byte(input logic [WORD_W-1:0] w,
                                                    input logic [2:0] idx);
        pick_byte = w[8*idx +: 8];
    endfunction

endpackage

@@ rtl/stream_find_replace.sv @@
// stream_find_replace: streaming byte find-and-replace, top level; depends on sfr_pkg.
// Steps: IDLE takes a byte, CHECK releases mismatch bytes one by one, then decides;
// REPL sends the replacement bytes and rechecks; FLUSH sends held bytes on the end mark.
// A stalled output holds the sequencer, and s_tready stays low until it is back in IDLE,
// so a new byte is taken only once the last one is done.
// Reset: aresetn synchronous, active low; clears count, sequencer, output valid, config.
module stream_find_replace #(
    parameter int unsigned MAX_PATTERN = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_stream
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // [0] out_valid
    output logic        m_tlast,    // last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data
);
    import sfr_pkg::*;

    // count holds 0..MAX_PATTERN; index into the pending line covers 0..MAX_PATTERN-1
    localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
    localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0] PLEN_CAP = LEN_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0] RLEN_CAP = LEN_W'(REPL_MAX);

    // sequencer and pending line
    sfr_state_t           state_reg, state_next;
    logic [BYTE_W-1:0]    pend_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]    pend_next [MAX_PATTERN];
    logic [CW-1:0]        count_reg, count_next;
    logic                 eos_reg, eos_next;        // current item closes the stream
    logic                 emitted_reg, emitted_next; // a beat went out for this item
    logic [2:0]           ridx_reg, ridx_next;      // replacement byte index

    // configuration
    logic [WORD_W-1:0]    pat_reg, pat_next;
    logic [LEN_W-1:0]     plen_reg, plen_next;
    logic [WORD_W-1:0]    repl_reg, repl_next;
    logic [LEN_W-1:0]     rlen_reg, rlen_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    // derived
    logic [LEN_W-1:0]     plen_eff, rlen_eff, count4, cmp_len;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic                 prefix_match, full_match, slot_free, cfg_wr;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // output slot can take a beat this cycle
    assign slot_free = !m_tvalid_reg || m_tready;

    // effective lengths: zero pattern length acts as one, both saturate
    always_comb begin
        if (plen_reg == '0) begin
            plen_eff = LEN_W'(1);
        end else if (plen_reg > PLEN_CAP) begin
            plen_eff = PLEN_CAP;
        end else begin
            plen_eff = plen_reg;
        end
        rlen_eff = (rlen_reg > RLEN_CAP) ? RLEN_CAP : rlen_reg;
    end

    assign count4  = LEN_W'(count_reg);
    assign cmp_len = (count4 < plen_eff) ? count4 : plen_eff;

    // prefix comparator: the one compare unit, reused every CHECK cycle
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            byte_ok[i] = (LEN_W'(i) >= cmp_len) || (pend_reg[i] == pat_reg[8*i +: 8]);
        end
    end

    assign prefix_match = &byte_ok;
    assign full_match   = prefix_match && (count4 >= plen_eff);

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        eos_next      = eos_reg;
        emitted_next  = emitted_reg;
        ridx_next     = ridx_reg;
        pat_next      = pat_reg;
        plen_next     = plen_reg;
        repl_next     = repl_reg;
        rlen_next     = rlen_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pend_next[count_reg[IW-1:0]] = s_tdata;
                    count_next   = count_reg + CW'(1);
                    eos_next     = s_tlast;
                    emitted_next = 1'b0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (count_reg == '0) begin
                    state_next = eos_reg ? ST_FLUSH : ST_IDLE;
                end else if (full_match) begin
                    if (rlen_eff == '0) begin
                        count_next = '0;        // deletion
                    end else begin
                        ridx_next  = '0;
                        state_next = ST_REPL;
                    end
                end else if (prefix_match) begin
                    // partial match: hold bytes unless the stream ends
                    state_next = eos_reg ? ST_FLUSH : ST_IDLE;
                end else if (slot_free) begin
                    // mismatch: oldest byte goes out, rest rechecked
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_reg[0];
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = eos_reg && (count_reg == CW'(1));
                    emitted_next  = 1'b1;
                    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                        pend_next[i] = pend_reg[i+1];
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            ST_REPL: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pick_byte(repl_reg, ridx_reg);
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = eos_reg && (LEN_W'(ridx_reg) == rlen_eff - LEN_W'(1));
                    emitted_next  = 1'b1;
                    if (LEN_W'(ridx_reg) == rlen_eff - LEN_W'(1)) begin
                        count_next = '0;        // match consumed whole buffer
                        state_next = ST_CHECK;
                    end else begin
                        ridx_next = ridx_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (count_reg == '0) begin
                    if (emitted_reg) begin
                        state_next = ST_IDLE;
                    end else if (slot_free) begin
                        // bare end marker
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tuser_next  = 1'b0;
                        m_tlast_next  = 1'b1;
                        emitted_next  = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_reg[0];
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = (count_reg == CW'(1));
                    emitted_next  = 1'b1;
                    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                        pend_next[i] = pend_reg[i+1];
                    end
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // config writes; search or pattern length changes drop pending bytes
        if (cfg_wr) begin
            case (cfg_addr)
                CFG_SEARCH: begin
                    pat_next   = cfg_data;
                    count_next = '0;
                end
                CFG_PAT_LEN: begin
                    plen_next  = cfg_data[LEN_W-1:0];
                    count_next = '0;
                end
                CFG_REPL: begin
                    repl_next = cfg_data;
                end
                CFG_REPL_LEN: begin
                    rlen_next = cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            eos_reg      <= 1'b0;
            emitted_reg  <= 1'b0;
            ridx_reg     <= '0;
            pat_reg      <= '0;
            plen_reg     <= LEN_W'(1);
            repl_reg     <= '0;
            rlen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            eos_reg      <= eos_next;
            emitted_reg  <= emitted_next;
            ridx_reg     <= ridx_next;
            pat_reg      <= pat_next;
            plen_reg     <= plen_next;
            repl_reg     <= repl_next;
            rlen_reg     <= rlen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

@@ rtl/sfr_checker.sv @@
// sfr_checker: port-level assertions for stream_find_replace, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    logic       out_stall;
    logic [9:0] out_beat;
    logic       bare_beat;
    logic       bare_ok;
    logic       in_take;

    assign out_stall = m_tvalid && !m_tready;
    assign out_beat  = {m_tdata, m_tuser, m_tlast};
    assign bare_beat = m_tvalid && !m_tuser;
    assign bare_ok   = m_tlast && (m_tdata == 8'd0);
    assign in_take   = s_tvalid && s_tready;

    // stalled result beat holds
    `SFR_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_beat), "beat changed in stall")

    // a bare marker only closes a stream and carries no byte
    `SFR_ASSERT_NOW(a_bare_last, bare_beat, bare_ok, "bare beat without last or with data")

    // an accepted beat keeps the input closed for the next cycle
    `SFR_ASSERT_NEXT(a_busy_after_take, in_take, !s_tready, "input ready right after a take")

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for stream_find_replace (find/replace on a byte stream).
// Depends on sfr_pkg and the stream_find_replace RTL; needs no files or arguments.

module tb_top;

    import sfr_pkg::*;

    localparam int unsigned PATTERN_MAX    = 8;
    localparam int unsigned BEATS_PER_ITEM = 8;    // most result beats one input byte can cause
    localparam int unsigned SETTLE_CYCLES  = 24;
    localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no beat on any channel
    localparam int unsigned ITEM_TARGET    = 370;
    localparam int unsigned CALM_AFTER     = 310;  // no idling once this many bytes are queued

    // indexes 4..7 decode to nothing; writes there must leave the block unchanged
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_LO = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } out_beat_t;

    // ------------------------------------------------------------------
    // clock, reset and DUT hookup; every input has a known value at time 0
    // ------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr  = 3'd0;
    logic [63:0] cfg_data  = 64'd0;

    always #5 aclk = ~aclk;

    stream_find_replace #(
        .MAX_PATTERN (PATTERN_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] in_byte
        .s_tlast   (s_tlast),    // end_of_stream
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] out_byte
        .m_tuser   (m_tuser),    // [0] out_valid
        .m_tlast   (m_tlast),    // last
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    in_beat_t    stream_q[$];     // bytes waiting for the driver
    out_beat_t   rewritten_q[$];  // predicted output beats, oldest first
    int unsigned items_queued = 0;
    int unsigned errors       = 0;
    bit          idle_on      = 1'b0;
    logic        in_fire      = 1'b0;
    int unsigned in_gap       = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet        = 0;

    // predictor copy of the registers and of the held partial match
    logic [63:0] find_word    = 64'd0;
    logic [3:0]  find_len_reg = 4'd1;
    logic [63:0] repl_word    = 64'd0;
    logic [3:0]  repl_len_reg = 4'd0;
    logic [7:0]  held [PATTERN_MAX];
    int unsigned held_cnt     = 0;
    int unsigned step_beats   = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    // zero counts as one, anything above the buffer size saturates
    function automatic int unsigned find_len();
        if (find_len_reg == 4'd0)
            return 1;
        if (find_len_reg > PATTERN_MAX)
            return PATTERN_MAX;
        return find_len_reg;
    endfunction

    function automatic void add_beat(input logic [7:0] d, input logic v);
        out_beat_t b;
        if (step_beats < BEATS_PER_ITEM) begin
            b.data  = d;
            b.valid = v;
            b.last  = 1'b0;
            rewritten_q.push_back(b);
            step_beats++;
        end
    endfunction

    function automatic void drop_held(input int unsigned k);
        int unsigned i;
        if (k >= held_cnt) begin
            held_cnt = 0;
        end else begin
            for (i = 0; i + k < held_cnt; i++)
                held[i] = held[i + k];
            held_cnt = held_cnt - k;
        end
    endfunction

    // Takes one accepted byte and queues the beats the block must produce for it.
    // A mismatch releases the oldest held byte and the rest is rescanned, which
    // keeps matches leftmost and non-overlapping.
    function automatic void rewrite_byte(input logic [7:0] b, input logic eos);
        int unsigned plen;
        int unsigned rlen;
        int unsigned span;
        int unsigned i;
        bit          hit;
        bit          waiting;
        out_beat_t   tail;
        plen = find_len();
        rlen = (repl_len_reg > REPL_MAX) ? REPL_MAX : repl_len_reg;
        step_beats = 0;
        if (held_cnt >= PATTERN_MAX)
            held_cnt = PATTERN_MAX - 1;
        held[held_cnt] = b;
        held_cnt++;
        waiting = 1'b0;
        while (held_cnt > 0 && !waiting) begin
            span = (held_cnt < plen) ? held_cnt : plen;
            hit  = 1'b1;
            for (i = 0; i < span; i++)
                if (held[i] != find_word[8*i +: 8])
                    hit = 1'b0;
            if (hit && held_cnt >= plen) begin
                for (i = 0; i < rlen; i++)
                    add_beat(repl_word[8*i +: 8], 1'b1);
                drop_held(plen);
            end else if (hit) begin
                waiting = 1'b1;            // prefix still open, hold it
            end else begin
                add_beat(held[0], 1'b1);
                drop_held(1);
            end
        end
        if (eos) begin
            for (i = 0; i < held_cnt; i++)
                add_beat(held[i], 1'b1);
            held_cnt = 0;
            if (step_beats == 0)
                add_beat(8'h00, 1'b0);     // bare end marker
            tail = rewritten_q.pop_back();
            tail.last = 1'b1;
            rewritten_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // input side: driver on the falling edge, acceptance on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            rewrite_byte(s_tdata, s_tlast);
    end

    always @(negedge aclk) begin : in_driver
        in_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (stream_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 11);
                s_tvalid <= 1'b0;
            end else begin
                nxt = stream_q.pop_front();
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.eos;
                s_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: random backpressure, checker on the rising edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string what, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : out_monitor
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (rewritten_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got data %h valid %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = rewritten_q.pop_front();
                check_field("out_byte", want.data, m_tdata);
                check_field("out_valid", {7'd0, want.valid}, {7'd0, m_tuser});
                check_field("last", {7'd0, want.last}, {7'd0, m_tlast});
            end
        end
    end

    // watchdog: any beat on any channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
                     $time, quiet, rewritten_q.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // Register write; the predictor takes it at the same edge as the block.
    // A search or length write throws away any held partial match.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_SEARCH: begin
                find_word = val;
                held_cnt  = 0;
            end
            CFG_PAT_LEN: begin
                find_len_reg = val[3:0];
                held_cnt     = 0;
            end
            CFG_REPL:     repl_word    = val;
            CFG_REPL_LEN: repl_len_reg = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_item(input logic [7:0] d, input logic eos);
        in_beat_t it;
        it.data = d;
        it.eos  = eos;
        stream_q.push_back(it);
        items_queued++;
    endfunction

    // wait until the stream is drained and every predicted beat has come out,
    // then give the block time to finish a byte that produced nothing
    task automatic settle();
        while (stream_q.size() != 0 || s_tvalid || rewritten_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // length register value; sometimes with junk above the low nibble
    function automatic logic [63:0] len_word(input logic [3:0] n);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
            w = 64'd0;
        w[3:0] = n;
        return w;
    endfunction

    task automatic pick_config();
        logic [63:0] word;
        logic [3:0]  n;
        int unsigned eff;
        int unsigned i;
        if ($urandom_range(0, 3) != 0) begin
            n = 4'($urandom_range(0, 11));
            if (n > 4'd9)
                n = 4'($urandom_range(9, 15));      // saturating lengths
            eff  = (n == 0) ? 1 : ((n > PATTERN_MAX) ? PATTERN_MAX : n);
            word = {$urandom, $urandom};
            // small alphabet most of the time so partial matches overlap
            if ($urandom_range(0, 3) != 0)
                for (i = 0; i < eff; i++)
                    word[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 2));
            write_reg(CFG_SEARCH, word);
            write_reg(CFG_PAT_LEN, len_word(n));
        end
        n = 4'($urandom_range(0, 10));
        if (n > 4'd8)
            n = 4'($urandom_range(9, 15));
        write_reg(CFG_REPL, {$urandom, $urandom});
        write_reg(CFG_REPL_LEN, len_word(n));
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_UNMAPPED_LO + 3'($urandom_range(0, 3)), {$urandom, $urandom});
    endtask

    // Mostly whole pattern copies and broken prefixes, plus pattern letters
    // and plain noise. close puts the end-of-stream mark on the last byte.
    task automatic queue_stream(input int unsigned n, input bit close);
        in_beat_t    run[$];
        in_beat_t    it;
        int unsigned plen;
        int unsigned pick;
        int unsigned k;
        int unsigned i;
        plen    = find_len();
        it.eos  = 1'b0;
        while (run.size() < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                for (i = 0; i < plen; i++) begin
                    it.data = find_word[8*i +: 8];
                    run.push_back(it);
                end
            end else if (pick < 55) begin
                k = $urandom_range(0, plen - 1);
                for (i = 0; i < k; i++) begin
                    it.data = find_word[8*i +: 8];
                    run.push_back(it);
                end
                it.data = 8'($urandom_range(0, 255));
                run.push_back(it);
            end else if (pick < 80) begin
                k = $urandom_range(0, plen - 1);
                it.data = find_word[8*k +: 8];
                run.push_back(it);
            end else begin
                it.data = 8'($urandom_range(0, 255));
                run.push_back(it);
            end
        end
        if (close) begin
            it = run.pop_back();
            it.eos = 1'b1;
            run.push_back(it);
        end
        items_queued = items_queued + run.size();
        while (run.size() != 0)
            stream_q.push_back(run.pop_front());
    endtask

    // a phase may stop mid-stream, so the next config write lands on held bytes
    task automatic random_phase();
        int unsigned n_streams;
        int unsigned s;
        bit          close;
        pick_config();
        n_streams = $urandom_range(1, 3);
        for (s = 0; s < n_streams; s++) begin
            close = (s + 1 < n_streams) || ($urandom_range(0, 4) != 0);
            queue_stream($urandom_range(1, 14), close);
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : test_seq
        integer i;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // reset values: single zero byte pattern, empty replacement, so zeros
        // vanish; a lone zero with the end mark gives a bare end marker
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b1);
        push_item(8'h00, 1'b1);
        settle();

        // "AAB" -> 8 bytes (length 15 saturates); "AAA" must release one A and
        // keep scanning; open prefix flushed at the end mark
        write_reg(CFG_SEARCH, 64'h0000_0000_0042_4141);
        write_reg(CFG_PAT_LEN, 64'd3);
        write_reg(CFG_REPL, 64'h8877_6655_4433_2211);
        write_reg(CFG_REPL_LEN, 64'd15);
        write_reg(CFG_UNMAPPED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(8'h41, 1'b0);
        push_item(8'h41, 1'b0);
        push_item(8'h41, 1'b0);
        push_item(8'h42, 1'b0);
        push_item(8'h43, 1'b0);
        push_item(8'h41, 1'b0);
        push_item(8'h41, 1'b1);
        settle();

        // leave an A held, then a length write of zero (acts as one) drops it;
        // empty replacement deletes each A
        push_item(8'h41, 1'b0);
        settle();
        write_reg(CFG_PAT_LEN, 64'd0);
        write_reg(CFG_REPL_LEN, 64'd0);
        push_item(8'h42, 1'b0);
        push_item(8'h41, 1'b0);
        push_item(8'h43, 1'b1);
        settle();

        // full 8-byte all-ones pattern (length 9 saturates), 8-byte replacement,
        // then a long open prefix broken by a zero on the end mark
        write_reg(CFG_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PAT_LEN, 64'd9);
        write_reg(CFG_REPL, 64'h00FF_00FF_00FF_00FF);
        write_reg(CFG_REPL_LEN, 64'd8);
        for (i = 0; i < 11; i = i + 1)
            push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b1);
        settle();

        // random phases; idling on or off per phase, none in the closing part
        while (items_queued < ITEM_TARGET) begin
            idle_on = (items_queued < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            random_phase();
        end

        if (errors == 0 && rewritten_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
